/* sv/mil_pkg.sv */
// shared types and constants for the message id lookup table
// field widths, lane layout of the key memory, request and response beats
// no dependencies
package mil_pkg;

  localparam int MIL_NUM_ENTRIES = 32;
  localparam int MIL_KEY_W       = 29;
  localparam int MIL_HANDLE_W    = 16;
  localparam int MIL_LANES       = 4;
  localparam int MIL_LANE_W      = 2;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_FIND   = 1'b1
  } mil_func_t;

  typedef struct packed {
    mil_func_t                 func;
    logic [MIL_KEY_W-1:0]      msg_key;
    logic [MIL_HANDLE_W-1:0]   handle_in;
  } mil_req_t;

  typedef struct packed {
    logic                      accepted;
    logic                      found;
    logic [MIL_HANDLE_W-1:0]   handle_out;
  } mil_rsp_t;

endpackage

/* sv/mil_key_mem.sv */
// key memory: rows of MIL_LANES keys, one lane written, one row read per cycle
// read data registered
// depends on mil_pkg
module mil_key_mem
  import mil_pkg::*;
#(
  parameter int ROWS  = 8,
  parameter int ROW_W = 3
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [ROW_W-1:0]                     wr_row,
  input  logic [MIL_LANE_W-1:0]                wr_lane,
  input  logic [MIL_KEY_W-1:0]                 wr_key,
  input  logic                                 rd_en,
  input  logic [ROW_W-1:0]                     rd_row,
  output logic [MIL_LANES-1:0][MIL_KEY_W-1:0]  rd_data
);

  logic [MIL_LANES-1:0][MIL_KEY_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_lane] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

/* sv/mil_handle_mem.sv */
// handle memory: one handle per entry slot
// single write port, single read port, read data registered
// depends on mil_pkg
module mil_handle_mem
  import mil_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int SLOT_W = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [SLOT_W-1:0]        wr_slot,
  input  logic [MIL_HANDLE_W-1:0]  wr_handle,
  input  logic                     rd_en,
  input  logic [SLOT_W-1:0]        rd_slot,
  output logic [MIL_HANDLE_W-1:0]  rd_data
);

  logic [MIL_HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

endmodule

/* sv/message_id_lookup_table.sv */
// message id lookup table: bounded map from 29-bit message id to 16-bit handle
// a scan reads the key rows in order until a hit or the last filled row (4 keys a row,
// one row read a cycle); a find hit then adds a read of the handle memory
// empty store or full-store insert: done the cycle after accept; one item at a time
// sync reset clears the entry count and control; memories are not cleared
// done is a one-cycle strobe, the receiver cannot stall it
module message_id_lookup_table
  import mil_pkg::*;
#(
  parameter int NUM_ENTRIES = MIL_NUM_ENTRIES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  mil_req_t req,
  output logic     busy,
  output logic     done,
  output mil_rsp_t rsp
);

  localparam int ROWS   = (NUM_ENTRIES + MIL_LANES - 1) / MIL_LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = ROW_W + MIL_LANE_W;
  localparam int CNT_W  = SLOT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_HWAIT = 3'b100
  } state_t;

  state_t                  state;
  mil_func_t               func_q;
  logic [MIL_KEY_W-1:0]    key_q;
  logic [MIL_HANDLE_W-1:0] hin_q;
  logic [CNT_W-1:0]        count;
  logic [ROW_W-1:0]        rd_row;
  logic                    issuing;
  logic                    chk_valid;
  logic [ROW_W-1:0]        chk_row;

  logic                                 accept;
  logic                                 full;
  logic                                 empty;
  logic [CNT_W-1:0]                     count_m1;
  logic [ROW_W-1:0]                     last_row;
  logic [MIL_LANES-1:0][MIL_KEY_W-1:0]  row_data;
  logic [MIL_LANES-1:0]                 lane_hit;
  logic                                 hit;
  logic [MIL_LANE_W-1:0]                hit_lane;
  logic                                 at_last;
  logic                                 key_rd_en;
  logic                                 wr_en;
  logic [SLOT_W-1:0]                    wr_slot;
  logic [MIL_KEY_W-1:0]                 wr_key;
  logic [MIL_HANDLE_W-1:0]              wr_handle;
  logic                                 h_rd_en;
  logic [MIL_HANDLE_W-1:0]              h_rd_data;
  logic                                 done_next;
  mil_rsp_t                             rsp_next;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (count >= CNT_W'(NUM_ENTRIES));
  assign empty    = (count == '0);
  assign count_m1 = count - CNT_W'(1);
  assign last_row = count_m1[SLOT_W-1:MIL_LANE_W];
  assign at_last  = (chk_row == last_row);

  // lane compare, masked to lanes below the fill count
  always_comb begin
    for (int l = 0; l < MIL_LANES; l++) begin
      lane_hit[l] = (CNT_W'({chk_row, MIL_LANE_W'(l)}) < count) && (row_data[l] == key_q);
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int l = MIL_LANES - 1; l >= 0; l--) begin
      if (lane_hit[l]) begin
        hit      = 1'b1;
        hit_lane = MIL_LANE_W'(l);
      end
    end
  end

  assign key_rd_en = (state == ST_SCAN) && issuing;
  assign h_rd_en   = (state == ST_SCAN) && chk_valid && hit && (func_q == FUNC_FIND);

  // new entry goes at the fill count: straight from the request when the store is empty
  always_comb begin
    wr_en     = 1'b0;
    wr_key    = key_q;
    wr_handle = hin_q;
    wr_slot   = count[SLOT_W-1:0];
    case (state)
      ST_IDLE: begin
        wr_en     = accept && (req.func == FUNC_INSERT) && empty;
        wr_key    = req.msg_key;
        wr_handle = req.handle_in;
      end
      ST_SCAN: begin
        wr_en = chk_valid && !hit && at_last && (func_q == FUNC_INSERT);
      end
      ST_HWAIT: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // result beat contents and strobe
  always_comb begin
    done_next = 1'b0;
    rsp_next  = rsp;
    case (state)
      ST_IDLE: begin
        if (accept && ((req.func == FUNC_INSERT && full) || empty)) begin
          done_next         = 1'b1;
          rsp_next          = '0;
          rsp_next.accepted = (req.func == FUNC_INSERT) && !full;
        end
      end
      ST_SCAN: begin
        if (chk_valid && (hit || at_last) && !(func_q == FUNC_FIND && hit)) begin
          done_next         = 1'b1;
          rsp_next          = '0;
          rsp_next.accepted = (func_q == FUNC_INSERT);
        end
      end
      ST_HWAIT: begin
        done_next           = 1'b1;
        rsp_next            = '0;
        rsp_next.found      = 1'b1;
        rsp_next.handle_out = h_rd_data;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  mil_key_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_row  (wr_slot[SLOT_W-1:MIL_LANE_W]),
    .wr_lane (wr_slot[MIL_LANE_W-1:0]),
    .wr_key  (wr_key),
    .rd_en   (key_rd_en),
    .rd_row  (rd_row),
    .rd_data (row_data)
  );

  mil_handle_mem #(
    .DEPTH  (ROWS * MIL_LANES),
    .SLOT_W (SLOT_W)
  ) u_handle_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_handle (wr_handle),
    .rd_en     (h_rd_en),
    .rd_slot   ({chk_row, hit_lane}),
    .rd_data   (h_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      done      <= 1'b0;
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done <= done_next;
      rsp  <= rsp_next;
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q <= req.func;
            key_q  <= req.msg_key;
            hin_q  <= req.handle_in;
            if (!(req.func == FUNC_INSERT && full) && !empty) begin
              state     <= ST_SCAN;
              rd_row    <= '0;
              issuing   <= 1'b1;
              chk_valid <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (chk_valid && (hit || at_last)) begin
            issuing   <= 1'b0;
            chk_valid <= 1'b0;
            if (func_q == FUNC_FIND && hit) begin
              state <= ST_HWAIT;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            chk_valid <= issuing;
            chk_row   <= rd_row;
            if (issuing) begin
              if (rd_row == last_row) begin
                issuing <= 1'b0;
              end else begin
                rd_row <= rd_row + ROW_W'(1);
              end
            end
          end
        end
        ST_HWAIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_ENTRIES))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(rst) || (done && count == $past(count) + CNT_W'(1))))
    else $error("entry count moved without an insert beat");

  a_busy_ends_with_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done || $past(rst)))
    else $error("busy dropped without a result beat");

  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.accepted && rsp.found))
    else $error("result beat both accepted and found");

  a_hwait_find_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HWAIT) |-> (func_q == FUNC_FIND))
    else $error("handle read wait on an insert");
`endif

endmodule
